>>> rtl/core/ppt_pkg.sv
// shared types and constants of the point-in-polygon test unit
// no dependencies
`default_nettype none

package ppt_pkg;

   localparam int COORD_W = 16;          // coordinate width
   localparam int DIFF_W  = COORD_W + 1; // difference of two coordinates
   localparam int PROD_W  = 2 * DIFF_W;  // product of two differences
   localparam int EDGE_W  = 11;          // crossing count as reported

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;

   typedef struct packed {
      logic [1:0]                op;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
   } req_type;

   typedef struct packed {
      logic              inside_res;
      logic [EDGE_W-1:0] edges_crossed;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } vtx_type;

endpackage

`default_nettype wire

>>> rtl/core/point_in_polygon_test_unit.sv
// top level of the point-in-polygon test unit
// uses ppt_pkg, ppt_front, ppt_queue and ppt_back
//
// Usage:
//  - input channel (push/full, req_data): op 0 clears the polygon, op 1 appends
//    the vertex (point_x, point_y), op 2 queries that point, op 3 is ignored.
//    Appends beyond MAX_VERTICES are dropped.
//  - result channel (empty/pop, rsp_data): one result per query, in order,
//    with the crossing count (low 11 bits) and its parity as inside_res.
//  - clear and append are handled in the front end. A query waits in a
//    two-entry queue, then walks the stored edges one per cycle from the
//    vertex memory; the back end takes the next query only when it is idle
//    and the result register is empty. The walk of n vertices makes n + 1
//    memory reads through the three-stage edge pipeline, then hands off
//    through the result register. An empty polygon answers without a walk.
//  - a clear is held in the front end until all queued queries are done.
//  - reset empties the polygon and both channels; memory contents are kept.
//  - when the receiver does not pop, the result waits in the output register,
//    the front end keeps taking appends and up to three more queries (two in
//    the queue, one in the front end), then full rises.
`default_nettype none

module point_in_polygon_test_unit #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              push,
   output logic             full,
   input  ppt_pkg::req_type req_data,
   output logic             empty,
   input  wire              pop,
   output ppt_pkg::rsp_type rsp_data
);
   import ppt_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int QRY_W = CNT_W + 2 * COORD_W;

   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   vtx_type          wr_vtx;
   logic             q_push, q_full, q_pop, q_empty, back_idle;
   logic [QRY_W-1:0] q_in, q_out;

   ppt_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_vtx    (wr_vtx),
      .q_push    (q_push),
      .q_data    (q_in),
      .q_full    (q_full),
      .q_empty   (q_empty),
      .back_idle (back_idle)
   );

   ppt_queue #(.DATA_W(QRY_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   ppt_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_vtx   (wr_vtx),
      .q_data   (q_out),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .idle     (back_idle),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

>>> rtl/core/ppt_front.sv
// front end: takes transactions, keeps the vertex count, issues vertex writes
// and hands queries to the query queue; uses ppt_pkg
`default_nettype none

module ppt_front #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      push,
   output logic                                     full,
   input  ppt_pkg::req_type                         req_data,
   output logic                                     wr_en,
   output logic [$clog2(MAX_VERTICES)-1:0]          wr_addr,
   output ppt_pkg::vtx_type                         wr_vtx,
   output logic                                     q_push,
   output logic [$clog2(MAX_VERTICES+1)+2*ppt_pkg::COORD_W-1:0] q_data,
   input  wire                                      q_full,
   input  wire                                      q_empty,
   input  wire                                      back_idle
);
   import ppt_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = $clog2(MAX_VERTICES);

   logic             hold_vld_ff, hold_vld_in;
   req_type          hold_ff, hold_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             drain;
   logic             accept;

   always_comb begin
      drain  = 1'b0;
      wr_en  = 1'b0;
      q_push = 1'b0;
      if (hold_vld_ff) begin
         case (hold_ff.op)
            OP_CLEAR: begin
               // wait until no query still reads the old polygon
               drain = back_idle && q_empty;
            end
            OP_APPEND: begin
               drain = 1'b1;
               wr_en = (count_ff < CNT_W'(MAX_VERTICES));
            end
            OP_QUERY: begin
               drain  = !q_full;
               q_push = !q_full;
            end
            default: begin
               drain = 1'b1;
            end
         endcase
      end
   end

   assign full    = hold_vld_ff && !drain;
   assign accept  = push && !full;
   assign wr_addr = count_ff[IDX_W-1:0];
   assign wr_vtx  = '{x: hold_ff.point_x, y: hold_ff.point_y};
   assign q_data  = {count_ff, hold_ff.point_x, hold_ff.point_y};

   always_comb begin
      count_in = count_ff;
      if (hold_vld_ff && drain && hold_ff.op == OP_CLEAR) begin
         count_in = '0;
      end else if (wr_en) begin
         count_in = count_ff + CNT_W'(1);
      end
      hold_in     = accept ? req_data : hold_ff;
      hold_vld_in = accept || (hold_vld_ff && !drain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_vld_ff <= 1'b0;
         count_ff    <= '0;
      end else begin
         hold_vld_ff <= hold_vld_in;
         count_ff    <= count_in;
      end
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

>>> rtl/core/ppt_queue.sv
// two-entry queue of pending queries between front and back end
// no dependencies
`default_nettype none

module ppt_queue #(
   parameter int DATA_W = 48
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               push,
   input  wire [DATA_W-1:0]  push_data,
   output logic              full,
   input  wire               pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);

   logic [DATA_W-1:0] entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == 2'd2);
   assign empty    = (fill_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ppt_back.sv
// back end: vertex memory, edge walk pipeline and result register
// uses ppt_pkg
`default_nettype none

module ppt_back #(
   parameter int MAX_VERTICES = 1024
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      wr_en,
   input  wire [$clog2(MAX_VERTICES)-1:0]           wr_addr,
   input  ppt_pkg::vtx_type                         wr_vtx,
   input  wire [$clog2(MAX_VERTICES+1)+2*ppt_pkg::COORD_W-1:0] q_data,
   input  wire                                      q_empty,
   output logic                                     q_pop,
   output logic                                     idle,
   output logic                                     empty,
   input  wire                                      pop,
   output ppt_pkg::rsp_type                         rsp_data
);
   import ppt_pkg::*;

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = $clog2(MAX_VERTICES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_DRAIN
   } state_type;

   // vertex memory
   logic signed [COORD_W-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] mem_y [MAX_VERTICES];

   state_type                 state_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic [CNT_W-1:0]          n_ff, k_ff;
   logic [EDGE_W-1:0]         cnt_ff;
   logic                      rsp_vld_ff;
   rsp_type                   rsp_ff;

   logic [CNT_W-1:0]          q_n;
   logic signed [COORD_W-1:0] q_x, q_y;
   logic [CNT_W-1:0]          rd_sel;
   logic                      rd_en;

   // pipeline registers
   logic                      s1_vld_ff, s1_first_ff, s1_last_ff;
   logic signed [COORD_W-1:0] rx_ff, ry_ff, prev_x_ff, prev_y_ff;
   logic                      s2_vld_ff, s2_last_ff, s2_ok_ff;
   logic signed [DIFF_W-1:0]  s2_da_ff, s2_dy_ff, s2_db_ff, s2_dx_ff;
   logic                      s3_vld_ff, s3_last_ff, s3_ok_ff;
   logic signed [PROD_W-1:0]  s3_p1_ff, s3_p2_ff;

   logic                      s2_vld_in, s2_ok_in;
   logic signed [COORD_W-1:0] xa, ya, xb, yb, xmax;
   logic signed [DIFF_W-1:0]  s2_da_in, s2_dy_in, s2_db_in, s2_dx_in;
   logic                      hit;
   logic [EDGE_W-1:0]         cnt_next;

   assign {q_n, q_x, q_y} = q_data;

   assign idle     = (state_ff == ST_IDLE);
   assign q_pop    = idle && !q_empty && !rsp_vld_ff;
   assign empty    = !rsp_vld_ff;
   assign rsp_data = rsp_ff;

   // first read fetches the last vertex so the closing edge comes first
   assign rd_en  = (state_ff == ST_READ);
   assign rd_sel = (k_ff == '0) ? n_ff - CNT_W'(1) : k_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_vtx.x;
         mem_y[wr_addr] <= wr_vtx.y;
      end
      if (rd_en) begin
         rx_ff <= mem_x[rd_sel[IDX_W-1:0]];
         ry_ff <= mem_y[rd_sel[IDX_W-1:0]];
      end
   end

   // edge setup: orient so that ya <= yb
   always_comb begin
      if (prev_y_ff < ry_ff) begin
         xa = prev_x_ff;
         ya = prev_y_ff;
         xb = rx_ff;
         yb = ry_ff;
      end else begin
         xa = rx_ff;
         ya = ry_ff;
         xb = prev_x_ff;
         yb = prev_y_ff;
      end
      xmax      = (xa > xb) ? xa : xb;
      s2_vld_in = s1_vld_ff && !s1_first_ff;
      s2_ok_in  = (prev_y_ff != ry_ff) && (py_ff > ya) && (py_ff <= yb) && (px_ff <= xmax);
      s2_da_in  = DIFF_W'(px_ff) - DIFF_W'(xa);
      s2_dy_in  = DIFF_W'(yb) - DIFF_W'(ya);
      s2_db_in  = DIFF_W'(py_ff) - DIFF_W'(ya);
      s2_dx_in  = DIFF_W'(xb) - DIFF_W'(xa);
   end

   assign hit      = s3_vld_ff && s3_ok_ff && (s3_p1_ff <= s3_p2_ff);
   assign cnt_next = cnt_ff + EDGE_W'(hit);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= rd_en;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s2_vld_ff;
      end
      s1_first_ff <= (k_ff == '0);
      s1_last_ff  <= (k_ff == n_ff);
      if (s1_vld_ff) begin
         prev_x_ff <= rx_ff;
         prev_y_ff <= ry_ff;
      end
      s2_last_ff <= s1_last_ff;
      s2_ok_ff   <= s2_ok_in;
      s2_da_ff   <= s2_da_in;
      s2_dy_ff   <= s2_dy_in;
      s2_db_ff   <= s2_db_in;
      s2_dx_ff   <= s2_dx_in;
      s3_last_ff <= s2_last_ff;
      s3_ok_ff   <= s2_ok_ff;
      s3_p1_ff   <= PROD_W'(s2_da_ff) * PROD_W'(s2_dy_ff);
      s3_p2_ff   <= PROD_W'(s2_db_ff) * PROD_W'(s2_dx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         k_ff       <= '0;
      end else begin
         if (pop && rsp_vld_ff) begin
            rsp_vld_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_pop) begin
                  px_ff  <= q_x;
                  py_ff  <= q_y;
                  n_ff   <= q_n;
                  k_ff   <= '0;
                  cnt_ff <= '0;
                  if (q_n == '0) begin
                     // empty polygon answers outside at once
                     rsp_vld_ff <= 1'b1;
                     rsp_ff     <= '{inside_res: 1'b0, edges_crossed: '0};
                  end else begin
                     state_ff <= ST_READ;
                  end
               end
            end
            ST_READ: begin
               k_ff <= k_ff + CNT_W'(1);
               if (k_ff == n_ff) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (s3_vld_ff && s3_last_ff) begin
                  rsp_vld_ff <= 1'b1;
                  rsp_ff     <= '{inside_res: cnt_next[0], edges_crossed: cnt_next};
                  state_ff   <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (s3_vld_ff) begin
            cnt_ff <= cnt_next;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/ppt_checker.sv
// port-level checks of the point-in-polygon test unit, bound to the top level
// uses ppt_pkg
`default_nettype none

module ppt_checker (
   input wire              clock,
   input wire              reset,
   input wire              full,
   input wire              empty,
   input wire              pop,
   input ppt_pkg::rsp_type rsp_data
);

   // reset drops any waiting result
   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result channel not empty after reset");

   // reset frees the input channel
   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input channel full after reset");

   // the inside flag is the parity of the crossing count
   a_parity: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_data.inside_res == rsp_data.edges_crossed[0]))
      else $error("inside flag disagrees with crossing count");

   // a waiting result holds until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed before pop");

endmodule

bind point_in_polygon_test_unit ppt_checker u_ppt_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

`default_nettype wire
